>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// combinational property checked on every clock edge out of reset
`define AST_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
// implication into the next cycle
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/oclp_pkg.sv
// ----------------------------------------------------------------------------
// oclp_pkg
// Types, constants and helpers of the camera motion low-pass filter.
// ----------------------------------------------------------------------------
package oclp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W  = 40;   // accumulator and average state
    localparam int WW     = 52;   // internal working width
    localparam int DIV_W  = 50;   // divider dividend / quotient
    localparam int DEN_W  = 14;   // divider divisor
    localparam int CNT_W  = 6;    // divider step counter
    localparam int X_W    = 30;
    localparam int ANG_W  = 20;
    localparam int ZM_W   = 24;
    localparam int DATA_W = 104;

    localparam logic signed [WW-1:0] ACC_MAX = 52'sd549755813887;
    localparam logic signed [WW-1:0] ACC_MIN = -52'sd549755813888;
    localparam logic signed [WW-1:0] XY_MAX  = 52'sd536870911;
    localparam logic signed [WW-1:0] XY_MIN  = -52'sd536870912;
    localparam logic signed [WW-1:0] ANG_MAX = 52'sd411775;
    localparam logic signed [WW-1:0] ANG_MIN = -52'sd411775;
    localparam logic signed [WW-1:0] ZM_MAX  = 52'sd6553600;
    localparam logic signed [WW-1:0] ZM_MIN  = -52'sd6553600;

    localparam logic [2:0] REG_SMOOTHING = 3'd0;
    localparam logic [2:0] REG_RELATIVE  = 3'd1;
    localparam logic [2:0] REG_MAX_SHIFT = 3'd2;
    localparam logic [2:0] REG_MAX_ANGLE = 3'd3;
    localparam logic [2:0] REG_OPT_ZOOM  = 3'd4;
    localparam logic [2:0] REG_GLB_ZOOM  = 3'd5;
    localparam logic [2:0] REG_FRAME_W   = 3'd6;
    localparam logic [2:0] REG_FRAME_H   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_AVG, ST_AVG_WAIT, ST_RES, ST_ACC_WAIT, ST_CLAMP,
        ST_ZX, ST_ZX_WAIT, ST_ZY, ST_ZY_WAIT, ST_ZA, ST_ZA_WAIT, ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [WW-1:0] sat(input logic signed [WW-1:0] v,
                                                 input logic signed [WW-1:0] lo,
                                                 input logic signed [WW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

>>> sv/online_camera_motion_lowpass.sv
// Divisions per request: none for the first one after reset; later ones 0 to 11,
//   three of them for the zoom estimate when it is on, all on the shared divider.
// Throughput: one request at a time; the shared bit-serial divider (one quotient bit
//   per cycle, 50 bits) sets it, and it drops further while m_tready is low.
// Reset (aresetn low, synchronous): config registers to defaults, filter state cleared.
// ----------------------------------------------------------------------------
// online_camera_motion_lowpass
// Exponential smoothing of per-frame camera motion with leaking residual
// accumulator, clamping, sliding required zoom and global zoom offset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module online_camera_motion_lowpass import oclp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request in: tdata = in_x[29:0], in_y[59:30], in_angle[79:60], in_zoom[103:80]
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    // result out: tdata = out_x[29:0], out_y[59:30], out_angle[79:60], out_zoom[103:80]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------- configuration registers ----------------
    logic [7:0]         smooth_reg;
    logic               rel_reg;
    logic signed [13:0] mshift_reg;
    logic signed [18:0] mangle_reg;
    logic               optz_reg;
    logic signed [22:0] gzoom_reg;
    logic [13:0]        fw_reg;
    logic [13:0]        fh_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= 8'd15;
            rel_reg    <= 1'b1;
            mshift_reg <= -14'sd1;
            mangle_reg <= -19'sd65536;
            optz_reg   <= 1'b1;
            gzoom_reg  <= '0;
            fw_reg     <= 14'd1920;
            fh_reg     <= 14'd1080;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_SMOOTHING: smooth_reg <= pwdata[7:0];
                REG_RELATIVE:  rel_reg    <= pwdata[0];
                REG_MAX_SHIFT: mshift_reg <= pwdata[13:0];
                REG_MAX_ANGLE: mangle_reg <= pwdata[18:0];
                REG_OPT_ZOOM:  optz_reg   <= pwdata[0];
                REG_GLB_ZOOM:  gzoom_reg  <= pwdata[22:0];
                REG_FRAME_W:   fw_reg     <= pwdata[13:0];
                REG_FRAME_H:   fh_reg     <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SMOOTHING: prdata = 32'(smooth_reg);
            REG_RELATIVE:  prdata = 32'(rel_reg);
            REG_MAX_SHIFT: prdata = 32'(unsigned'(mshift_reg));
            REG_MAX_ANGLE: prdata = 32'(unsigned'(mangle_reg));
            REG_OPT_ZOOM:  prdata = 32'(optz_reg);
            REG_GLB_ZOOM:  prdata = 32'(unsigned'(gzoom_reg));
            REG_FRAME_W:   prdata = 32'(fw_reg);
            REG_FRAME_H:   prdata = 32'(fh_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- datapath state ----------------
    state_t                   state_reg, state_next;
    logic [1:0]               fidx_reg, fidx_next;
    logic                     seen_reg, seen_next;
    logic                     zero_reg, zero_next;   // first item: all-zero result
    logic                     neg_reg, neg_next;     // sign of the running division
    logic signed [X_W-1:0]    v_reg [4];
    logic signed [X_W-1:0]    v_next [4];
    logic signed [ACC_W-1:0]  avg_reg [4];
    logic signed [ACC_W-1:0]  avg_next [4];
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic signed [ACC_W-1:0]  acc_next [4];
    logic signed [ACC_W-1:0]  res_reg [4];
    logic signed [ACC_W-1:0]  res_next [4];
    logic signed [ACC_W-1:0]  za_reg, za_next;
    logic [DIV_W-1:0]         zx_reg, zx_next;
    logic [DIV_W-1:0]         zy_reg, zy_next;
    logic                     mv_reg, mv_next;
    logic [DATA_W-1:0]        md_reg, md_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    oclp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // divisors
    logic             sm_on;
    logic [DEN_W-1:0] n_den, n3_den, w_den, h_den;
    assign sm_on  = (smooth_reg != '0);
    assign n_den  = DEN_W'(smooth_reg) + DEN_W'(1);
    assign n3_den = n_den + (n_den << 1);
    assign w_den  = (fw_reg == '0) ? DEN_W'(1) : fw_reg;
    assign h_den  = (fh_reg == '0) ? DEN_W'(1) : fh_reg;

    // per-field operands
    logic signed [WW-1:0] cur_v, cur_avg, cur_acc, cur_res, cur_t, q_s;
    logic signed [WW-1:0] r0_abs, r1_abs, za_w, za_diff, za_new;
    logic [DIV_W-1:0]     req_z;
    logic signed [WW-1:0] ms_w, ma_w, m_lim;
    logic signed [WW-1:0] div_a;

    assign cur_v   = WW'(v_reg[fidx_reg]);
    assign cur_avg = WW'(avg_reg[fidx_reg]);
    assign cur_acc = WW'(acc_reg[fidx_reg]);
    assign cur_res = cur_v - cur_avg;
    assign cur_t   = sat(cur_res + cur_acc, ACC_MIN, ACC_MAX);
    assign q_s     = neg_reg ? -signed'(WW'(div_rsp.quot)) : signed'(WW'(div_rsp.quot));

    assign r0_abs  = (res_reg[0] < 0) ? -WW'(res_reg[0]) : WW'(res_reg[0]);
    assign r1_abs  = (res_reg[1] < 0) ? -WW'(res_reg[1]) : WW'(res_reg[1]);
    assign req_z   = (zx_reg > zy_reg) ? zx_reg : zy_reg;
    assign za_w    = WW'(za_reg);
    assign za_diff = signed'(WW'(req_z)) - za_w;
    assign za_new  = sat(za_w + q_s, ACC_MIN, ACC_MAX);

    assign ms_w    = WW'(mshift_reg);
    assign ma_w    = WW'(mangle_reg);
    assign m_lim   = ms_w <<< FRAC_BITS;

    // output saturation
    logic signed [WW-1:0] o_x, o_y, o_a, o_z, gz_w;
    assign gz_w = zero_reg ? '0 : WW'(gzoom_reg);
    assign o_x  = sat(WW'(res_reg[0]), XY_MIN, XY_MAX);
    assign o_y  = sat(WW'(res_reg[1]), XY_MIN, XY_MAX);
    assign o_a  = sat(WW'(res_reg[2]), ANG_MIN, ANG_MAX);
    assign o_z  = sat(WW'(res_reg[3]) + gz_w, ZM_MIN, ZM_MAX);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    // states in which a quotient may come back
    logic div_wait;
    assign div_wait = state_reg inside {ST_AVG_WAIT, ST_ACC_WAIT, ST_ZX_WAIT,
                                        ST_ZY_WAIT, ST_ZA_WAIT};

    always_comb begin
        state_next = state_reg;
        fidx_next  = fidx_reg;
        seen_next  = seen_reg;
        zero_next  = zero_reg;
        neg_next   = neg_reg;
        v_next     = v_reg;
        avg_next   = avg_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        za_next    = za_reg;
        zx_next    = zx_reg;
        zy_next    = zy_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        div_a      = '0;
        div_req.start = 1'b0;
        div_req.den   = n_den;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    v_next[0] = s_tdata[29:0];
                    v_next[1] = s_tdata[59:30];
                    v_next[2] = X_W'($signed(s_tdata[79:60]));
                    v_next[3] = X_W'($signed(s_tdata[103:80]));
                    fidx_next = '0;
                    zero_next = !seen_reg;
                    if (!seen_reg) begin
                        // first request seeds the averages, result is zero
                        avg_next[0] = ACC_W'($signed(s_tdata[29:0]));
                        avg_next[1] = ACC_W'($signed(s_tdata[59:30]));
                        avg_next[2] = ACC_W'($signed(s_tdata[79:60]));
                        avg_next[3] = ACC_W'($signed(s_tdata[103:80]));
                        for (int i = 0; i < 4; i++) begin
                            acc_next[i] = '0;
                            res_next[i] = '0;
                        end
                        za_next    = '0;
                        seen_next  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                if (sm_on) begin
                    div_a         = cur_v - cur_avg;
                    div_req.start = 1'b1;
                    neg_next      = div_a < 0;
                    state_next    = ST_AVG_WAIT;
                end else begin
                    avg_next[fidx_reg] = ACC_W'(cur_v);
                    state_next         = ST_RES;
                end
            end
            ST_AVG_WAIT: begin
                if (div_rsp.done) begin
                    avg_next[fidx_reg] = ACC_W'(cur_avg + q_s);
                    state_next         = ST_RES;
                end
            end
            ST_RES: begin
                if (rel_reg) begin
                    acc_next[fidx_reg] = ACC_W'(cur_t);
                    res_next[fidx_reg] = ACC_W'(cur_t);
                end else begin
                    res_next[fidx_reg] = ACC_W'(cur_res);
                end
                if (rel_reg && sm_on) begin
                    // leak: acc -= rdiv(acc, 3n)
                    div_a         = cur_t;
                    div_req.start = 1'b1;
                    div_req.den   = n3_den;
                    neg_next      = div_a < 0;
                    state_next    = ST_ACC_WAIT;
                end else if (fidx_reg == 2'd3) begin
                    state_next = ST_CLAMP;
                end else begin
                    fidx_next  = fidx_reg + 1'b1;
                    state_next = ST_AVG;
                end
            end
            ST_ACC_WAIT: begin
                if (div_rsp.done) begin
                    acc_next[fidx_reg] = ACC_W'(cur_acc - q_s);
                    if (fidx_reg == 2'd3) begin
                        state_next = ST_CLAMP;
                    end else begin
                        fidx_next  = fidx_reg + 1'b1;
                        state_next = ST_AVG;
                    end
                end
            end
            ST_CLAMP: begin
                if (ms_w >= 0) begin
                    res_next[0] = ACC_W'(sat(WW'(res_reg[0]), -m_lim, m_lim));
                    res_next[1] = ACC_W'(sat(WW'(res_reg[1]), -m_lim, m_lim));
                end
                if (ma_w >= 0) begin
                    res_next[2] = ACC_W'(sat(WW'(res_reg[2]), -ma_w, ma_w));
                end
                state_next = (optz_reg && sm_on) ? ST_ZX : ST_OUT;
            end
            ST_ZX: begin
                div_a         = (r0_abs <<< 7) + (r0_abs <<< 6) + (r0_abs <<< 3);
                div_req.start = 1'b1;
                div_req.den   = w_den;
                neg_next      = 1'b0;
                state_next    = ST_ZX_WAIT;
            end
            ST_ZX_WAIT: begin
                if (div_rsp.done) begin
                    zx_next    = div_rsp.quot;
                    state_next = ST_ZY;
                end
            end
            ST_ZY: begin
                div_a         = (r1_abs <<< 7) + (r1_abs <<< 6) + (r1_abs <<< 3);
                div_req.start = 1'b1;
                div_req.den   = h_den;
                neg_next      = 1'b0;
                state_next    = ST_ZY_WAIT;
            end
            ST_ZY_WAIT: begin
                if (div_rsp.done) begin
                    zy_next    = div_rsp.quot;
                    state_next = ST_ZA;
                end
            end
            ST_ZA: begin
                div_a         = za_diff;
                div_req.start = 1'b1;
                neg_next      = div_a < 0;
                state_next    = ST_ZA_WAIT;
            end
            ST_ZA_WAIT: begin
                if (div_rsp.done) begin
                    za_next     = ACC_W'(za_new);
                    res_next[3] = ACC_W'(za_new);
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {o_z[ZM_W-1:0], o_a[ANG_W-1:0],
                                  o_y[X_W-1:0], o_x[X_W-1:0]};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        div_req.mag = (div_a < 0) ? DIV_W'(-div_a) : DIV_W'(div_a);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seen_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                avg_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
            za_reg    <= '0;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            mv_reg    <= mv_next;
            avg_reg   <= avg_next;
            acc_reg   <= acc_next;
            za_reg    <= za_next;
        end
        fidx_reg <= fidx_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        zx_reg   <= zx_next;
        zy_reg   <= zy_next;
        md_reg   <= md_next;
    end

    // ---------------- assertions ----------------
    `AST_ALWAYS(a_div_free, !(div_req.start && div_rsp.busy), "divider started while busy")
    `AST_ALWAYS(a_div_done, !div_rsp.done || div_wait, "quotient outside a wait state")
    `AST_NEXT(a_out_hold, state_reg == ST_OUT && mv_reg && !m_tready, state_reg == ST_OUT, "result lost")

endmodule

>>> sv/oclp_div.sv
// ----------------------------------------------------------------------------
// oclp_div
// Bit-serial restoring divider, rounds half away from zero on magnitudes.
// ----------------------------------------------------------------------------
module oclp_div import oclp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg, q_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            // bias by half the divisor for rounding
            q_next   = req.mag + DIV_W'(req.den >> 1);
            rem_next = '0;
            den_next = req.den;
            cnt_next = CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            q_next    = {q_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule
